// File: rtl/tlbe_pkg.sv
// Shared constants and types for the terminal line buffer with echo.
// No dependencies; used by rtl/terminal_line_buffer_with_echo.sv.
package tlbe_pkg;

  // Depth of the receive line and of the transmit queue.
  localparam int BUF_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Fixed field widths of the item formats.
  localparam int KIND_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 10;
  localparam int COUNT_OUT_W = 11;

  // Width for comparing the read index against the line count.
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [BYTE_W-1:0] BS_RESET = 8'h08;

  typedef enum logic [KIND_W-1:0] {
    KIND_RX    = 3'd0,
    KIND_TX    = 3'd1,
    KIND_IDLE  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

endpackage

// File: rtl/terminal_line_buffer_with_echo.sv
// Top level of the terminal line buffer with echo and transmit queue.
// Depends on rtl/tlbe_pkg.sv; holds both byte memories inline.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tuser: kind; in_tdata: byte_in,
//          |     |                        |   read_index, line_ready
//  out_    | out | out_tvalid / out_tready| out_tdata: tx_valid, tx_byte, read_data,
//          |     |                        |   line_count, queue_count, drop flags
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: backspace code
//
// For each item, the accept cycle addresses the line and queue memories
// (registered read) and updates all counters; then the result state loads
// the result register from the memory read data once the output is free.
// The result register parts the two sides, so a stalled result only holds
// the block in its result state. Reset (rst_n low, synchronous) empties line
// and queue and sets the backspace code to 0x08; memory contents are left as they are.
module terminal_line_buffer_with_echo (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlbe_pkg::BYTE_W-1:0]       cfg_data,    // [7:0] backspace_code
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tlbe_pkg::KIND_W-1:0]       in_tuser,    // [2:0] kind
  input  logic [tlbe_pkg::IN_DATA_W-1:0]    in_tdata,    // [7:0] byte_in, [17:8] read_index,
                                                         // [18] line_ready, [23:19] zero
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlbe_pkg::OUT_DATA_W-1:0]   out_tdata    // [0] tx_valid, [8:1] tx_byte,
                                                         // [16:9] read_data, [27:17] line_count,
                                                         // [38:28] queue_count, [39] line_dropped,
                                                         // [40] queue_dropped, [47:41] zero
);

  localparam int AW = tlbe_pkg::ADDR_W;
  localparam int CW = tlbe_pkg::CNT_W;
  localparam int BW = tlbe_pkg::BYTE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(tlbe_pkg::BUF_DEPTH);

  // Unpack the input item.
  logic [BW-1:0]                 in_byte;
  logic [tlbe_pkg::INDEX_W-1:0]  in_index;
  logic                          in_ready_line;
  tlbe_pkg::kind_t               in_kind;

  assign in_byte       = in_tdata[7:0];
  assign in_index      = in_tdata[17:8];
  assign in_ready_line = in_tdata[18];
  assign in_kind       = tlbe_pkg::kind_t'(in_tuser);

  // Control state.
  tlbe_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]    bs_r;
  logic [CW-1:0]    line_fill_r, line_fill_nxt;
  logic [CW-1:0]    queue_fill_r, queue_fill_nxt;
  logic [AW-1:0]    queue_head_r, queue_head_nxt;
  logic             out_valid_r;

  // Result fields captured at accept, waiting for the memory read data.
  logic             pend_tx_valid_r, pend_tx_valid_nxt;
  logic             pend_fwd_r, pend_fwd_nxt;
  logic [BW-1:0]    pend_fwd_byte_r;
  logic             pend_rd_ok_r, pend_rd_ok_nxt;
  logic             pend_line_drop_r, pend_line_drop_nxt;
  logic             pend_queue_drop_r, pend_queue_drop_nxt;

  logic [tlbe_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Memories and their ports.
  logic [BW-1:0] line_mem  [tlbe_pkg::BUF_DEPTH];
  logic [BW-1:0] queue_mem [tlbe_pkg::BUF_DEPTH];
  logic [BW-1:0] line_q_r, queue_q_r;
  logic          line_we, queue_we;
  logic [AW-1:0] line_waddr, queue_waddr, line_raddr;

  logic accept, load_out;

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Queue tail: head plus fill, wrapped once.
  logic [CW:0] tail_sum;
  assign tail_sum    = (CW+1)'(queue_head_r) + (CW+1)'(queue_fill_r);
  assign queue_waddr = (tail_sum >= (CW+1)'(tlbe_pkg::BUF_DEPTH))
                       ? AW'(tail_sum - (CW+1)'(tlbe_pkg::BUF_DEPTH)) : AW'(tail_sum);
  assign line_waddr  = AW'(line_fill_r);
  assign line_raddr  = AW'(in_index);

  // Item decode: line and queue updates, echo and send decision.
  always_comb begin
    logic          push;
    logic [CW-1:0] qf_mid;
    push                = 1'b0;
    line_we             = 1'b0;
    line_fill_nxt       = line_fill_r;
    pend_rd_ok_nxt      = 1'b0;
    pend_line_drop_nxt  = 1'b0;
    pend_queue_drop_nxt = 1'b0;
    unique case (in_kind)
      tlbe_pkg::KIND_RX: begin
        if (in_byte == bs_r) begin
          if (line_fill_r != '0) begin
            line_fill_nxt = line_fill_r - CW'(1);
            push          = 1'b1;
          end
        end else if (line_fill_r < DEPTH_C) begin
          line_we       = 1'b1;
          line_fill_nxt = line_fill_r + CW'(1);
          push          = 1'b1;
        end else begin
          pend_line_drop_nxt = 1'b1;
        end
      end
      tlbe_pkg::KIND_TX:    push = 1'b1;
      tlbe_pkg::KIND_READ:  pend_rd_ok_nxt =
                              tlbe_pkg::CMP_W'(in_index) < tlbe_pkg::CMP_W'(line_fill_r);
      tlbe_pkg::KIND_CLEAR: line_fill_nxt = '0;
      default: ;  // idle tick and unused kinds
    endcase

    queue_we = 1'b0;
    qf_mid   = queue_fill_r;
    if (push) begin
      if (queue_fill_r < DEPTH_C) begin
        queue_we = 1'b1;
        qf_mid   = queue_fill_r + CW'(1);
      end else begin
        pend_queue_drop_nxt = 1'b1;
      end
    end

    // Send the oldest byte; an empty queue forwards the byte just pushed.
    pend_tx_valid_nxt = in_ready_line && (qf_mid != '0);
    pend_fwd_nxt      = (queue_fill_r == '0);
    queue_fill_nxt    = qf_mid;
    queue_head_nxt    = queue_head_r;
    if (pend_tx_valid_nxt) begin
      queue_fill_nxt = qf_mid - CW'(1);
      queue_head_nxt = (queue_head_r == AW'(tlbe_pkg::BUF_DEPTH - 1))
                       ? '0 : queue_head_r + AW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlbe_pkg::ST_IDLE: if (in_tvalid) state_nxt = tlbe_pkg::ST_RESP;
      tlbe_pkg::ST_RESP: if (!out_valid_r || out_tready) state_nxt = tlbe_pkg::ST_IDLE;
      default:           state_nxt = tlbe_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      tlbe_pkg::ST_IDLE: in_tready = 1'b1;
      tlbe_pkg::ST_RESP: load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Assemble the result from the pending fields and the read data.
  always_comb begin
    logic [BW-1:0] tx_b, rd_b;
    tx_b = '0;
    if (pend_tx_valid_r) tx_b = pend_fwd_r ? pend_fwd_byte_r : queue_q_r;
    rd_b = pend_rd_ok_r ? line_q_r : '0;
    out_data_nxt = '0;
    out_data_nxt[0]     = pend_tx_valid_r;
    out_data_nxt[8:1]   = tx_b;
    out_data_nxt[16:9]  = rd_b;
    out_data_nxt[27:17] = tlbe_pkg::COUNT_OUT_W'(line_fill_r);
    out_data_nxt[38:28] = tlbe_pkg::COUNT_OUT_W'(queue_fill_r);
    out_data_nxt[39]    = pend_line_drop_r;
    out_data_nxt[40]    = pend_queue_drop_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlbe_pkg::ST_IDLE;
      bs_r         <= tlbe_pkg::BS_RESET;
      line_fill_r  <= '0;
      queue_fill_r <= '0;
      queue_head_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) bs_r <= cfg_data;
      if (accept) begin
        line_fill_r  <= line_fill_nxt;
        queue_fill_r <= queue_fill_nxt;
        queue_head_r <= queue_head_nxt;
      end
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers: hold pending fields from accept to result load.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_tx_valid_r   <= pend_tx_valid_nxt;
      pend_fwd_r        <= pend_fwd_nxt;
      pend_fwd_byte_r   <= in_byte;
      pend_rd_ok_r      <= pend_rd_ok_nxt;
      pend_line_drop_r  <= pend_line_drop_nxt;
      pend_queue_drop_r <= pend_queue_drop_nxt;
    end
    if (load_out) out_data_r <= out_data_nxt;
  end

  // Line memory: write at the fill point, read at the requested index.
  always_ff @(posedge clk) begin
    if (accept && line_we) line_mem[line_waddr] <= in_byte;
    if (accept)            line_q_r <= line_mem[line_raddr];
  end

  // Queue memory: write at the tail, read at the head. They meet only on
  // an empty queue, where the pushed byte is forwarded instead.
  always_ff @(posedge clk) begin
    if (accept && queue_we) queue_mem[queue_waddr] <= in_byte;
    if (accept)             queue_q_r <= queue_mem[queue_head_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_line_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_fill_r <= DEPTH_C)
    else $error("line fill beyond depth");

  a_queue_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_fill_r <= DEPTH_C)
    else $error("queue fill beyond depth");

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == tlbe_pkg::ST_RESP) && !in_tready)
    else $error("accepted item not followed by result cycle");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid)
    else $error("result load did not raise out_tvalid");
`endif

endmodule
